/* hdl/mcae_pkg.sv */
// Package with the shared types, codes and constants of the autoscroll engine.
`timescale 1ns / 1ps

package mcae_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int ACC_INT_BITS = 18;
    localparam int ACC_W        = FRAC_BITS + ACC_INT_BITS;
    localparam int STEP_SHIFT   = 32 - FRAC_BITS;
    localparam int INC_W        = 48 - STEP_SHIFT;
    localparam int MUL_A_W      = 32;
    localparam int MUL_B_W      = 16;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_MID_PRESS   = 3'd1,
        KIND_MID_RELEASE = 3'd2,
        KIND_WHEEL       = 3'd3,
        KIND_LR_PRESS    = 3'd4,
        KIND_ESCAPE      = 3'd5,
        KIND_TOGGLE      = 3'd6,
        KIND_NONE        = 3'd7
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE      = 3'd0,
        REG_LINEAR_GAIN    = 3'd1,
        REG_QUADRATIC_GAIN = 3'd2,
        REG_SPEED_CAP      = 3'd3,
        REG_MAX_STEP       = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SHAPE_NORMAL = 2'd0,
        SHAPE_MIDDLE = 2'd1,
        SHAPE_NORTH  = 2'd2,
        SHAPE_SOUTH  = 2'd3
    } shape_t;

    typedef struct packed {
        logic [9:0]  dead_zone;
        logic [15:0] linear_gain;
        logic [15:0] quadratic_gain;
        logic [15:0] speed_cap;
        logic [15:0] max_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dead_zone:      10'd15,
        linear_gain:    16'd2560,
        quadratic_gain: 16'd6554,
        speed_cap:      16'd15000,
        max_step:       16'd6554
    };

    typedef struct packed {
        logic signed [15:0]      anchor_y;
        logic signed [15:0]      pos_y;
        logic [15:0]             elapsed;
        logic signed [ACC_W-1:0] acc;
    } tick_req_t;

    typedef struct packed {
        logic                    dead_hit;
        logic                    go_down;
        logic                    step_valid;
        logic signed [15:0]      delta;
        logic signed [ACC_W-1:0] acc;
    } tick_rsp_t;

endpackage

/* hdl/mcae_in_if.sv */
// Input channel carrying one pointer or key event word.
`timescale 1ns / 1ps

interface mcae_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               over_target;
    logic [15:0]        elapsed;
    logic               target_ok;

    modport source (output valid, kind, pos_x, pos_y, over_target, elapsed, target_ok,
                    input ready);
    modport sink (input valid, kind, pos_x, pos_y, over_target, elapsed, target_ok,
                  output ready);
endinterface

/* hdl/mcae_out_if.sv */
// Output channel carrying one result word of the autoscroll engine.
`timescale 1ns / 1ps

interface mcae_out_if;
    logic               valid;
    logic               ready;
    logic               wheel_valid;
    logic signed [15:0] wheel_delta;
    logic signed [15:0] wheel_x;
    logic signed [15:0] wheel_y;
    logic [1:0]         cursor_shape;
    logic               scrolling_now;
    logic               enabled_now;
    logic               swallow;

    modport source (output valid, wheel_valid, wheel_delta, wheel_x, wheel_y, cursor_shape,
                    scrolling_now, enabled_now, swallow, input ready);
    modport sink (input valid, wheel_valid, wheel_delta, wheel_x, wheel_y, cursor_shape,
                  scrolling_now, enabled_now, swallow, output ready);
endinterface

/* hdl/mcae_cfg_if.sv */
// Configuration write channel with register index and data.
`timescale 1ns / 1ps

interface mcae_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mcae_pkg::CFG_IDX_W-1:0]  index;
    logic [mcae_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/middle_click_autoscroll_engine_unit.sv */
// Top level of the middle-click autoscroll engine.
`timescale 1ns / 1ps
// The block takes pointer and key event words on the item channel and gives
// one result word for each of them on the result channel, in order. The cfg
// channel writes the five tuning registers and is always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// An event is taken when item.valid and item.ready are high at a clock edge.
// After that the block is busy until the result word is loaded into the
// output register. A press, release, wheel, escape or toggle event passes
// through the decode and write states before its word is loaded. A tick
// while scrolling runs the speed and step arithmetic through one shared
// multiplier under a small sequencer between those states, and a new tick
// waits for the old word to be loaded. A dead-zone tick ends at the distance step.
// The output register holds a finished word while result.ready is low; the
// block then accepts and works on the next event and waits only when that
// event's word is ready before the previous one has been taken.
// Reset loads the default tuning, enables the feature, stops scrolling,
// clears the accumulator and shows the normal cursor.

module middle_click_autoscroll_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    mcae_in_if.sink    item,
    mcae_out_if.source result,
    mcae_cfg_if.sink   cfg
);
    import mcae_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_TICK, S_WRITE} state_t;

    state_t                  state_reg;
    logic                    enabled_reg;
    logic                    scrolling_reg;
    logic                    dragged_reg;
    logic signed [15:0]      anchor_x_reg;
    logic signed [15:0]      anchor_y_reg;
    logic signed [ACC_W-1:0] acc_reg;
    shape_t                  shape_reg;

    logic [2:0]              kind_reg;
    logic signed [15:0]      pos_x_reg;
    logic signed [15:0]      pos_y_reg;
    logic                    over_reg;
    logic [15:0]             elapsed_reg;
    logic                    ok_reg;

    logic                    pend_wv_reg;
    logic signed [15:0]      pend_delta_reg;
    logic                    pend_swallow_reg;

    logic                    out_valid_reg;
    logic                    out_wv_reg;
    logic signed [15:0]      out_delta_reg;
    logic signed [15:0]      out_x_reg;
    logic signed [15:0]      out_y_reg;
    logic [1:0]              out_shape_reg;
    logic                    out_scroll_reg;
    logic                    out_enabled_reg;
    logic                    out_swallow_reg;

    cfg_t                    cfg_regs;
    tick_req_t               tick_req;
    tick_rsp_t               tick_rsp;
    logic                    tick_start;
    logic                    tick_done;

    mcae_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    assign tick_start = (state_reg == S_DECODE) && (kind_t'(kind_reg) == KIND_TICK) &&
                        scrolling_reg && enabled_reg && ok_reg;
    assign tick_req   = '{anchor_y: anchor_y_reg, pos_y: pos_y_reg,
                          elapsed: elapsed_reg, acc: acc_reg};

    mcae_tick u_tick (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tick_start),
        .req   (tick_req),
        .cfg   (cfg_regs),
        .done  (tick_done),
        .rsp   (tick_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            enabled_reg      <= 1'b1;
            scrolling_reg    <= 1'b0;
            dragged_reg      <= 1'b0;
            anchor_x_reg     <= '0;
            anchor_y_reg     <= '0;
            acc_reg          <= '0;
            shape_reg        <= SHAPE_NORMAL;
            kind_reg         <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            over_reg         <= 1'b0;
            elapsed_reg      <= '0;
            ok_reg           <= 1'b0;
            pend_wv_reg      <= 1'b0;
            pend_delta_reg   <= '0;
            pend_swallow_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_wv_reg       <= 1'b0;
            out_delta_reg    <= '0;
            out_x_reg        <= '0;
            out_y_reg        <= '0;
            out_shape_reg    <= '0;
            out_scroll_reg   <= 1'b0;
            out_enabled_reg  <= 1'b0;
            out_swallow_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        kind_reg    <= item.kind;
                        pos_x_reg   <= item.pos_x;
                        pos_y_reg   <= item.pos_y;
                        over_reg    <= item.over_target;
                        elapsed_reg <= item.elapsed;
                        ok_reg      <= item.target_ok;
                        state_reg   <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    pend_wv_reg      <= 1'b0;
                    pend_delta_reg   <= '0;
                    pend_swallow_reg <= 1'b0;
                    state_reg        <= S_WRITE;
                    unique case (kind_t'(kind_reg))
                        KIND_TICK:
                        begin
                            if (scrolling_reg && enabled_reg)
                            begin
                                if (ok_reg)
                                begin
                                    state_reg <= S_TICK;
                                end
                                else
                                begin
                                    scrolling_reg <= 1'b0;
                                    acc_reg       <= '0;
                                    shape_reg     <= SHAPE_NORMAL;
                                end
                            end
                        end
                        KIND_MID_PRESS:
                        begin
                            if (enabled_reg && over_reg)
                            begin
                                if (scrolling_reg)
                                begin
                                    scrolling_reg <= 1'b0;
                                    shape_reg     <= SHAPE_NORMAL;
                                end
                                else
                                begin
                                    anchor_x_reg  <= pos_x_reg;
                                    anchor_y_reg  <= pos_y_reg;
                                    dragged_reg   <= 1'b0;
                                    scrolling_reg <= 1'b1;
                                    shape_reg     <= SHAPE_MIDDLE;
                                end
                                acc_reg          <= '0;
                                pend_swallow_reg <= 1'b1;
                            end
                        end
                        KIND_MID_RELEASE:
                        begin
                            if (enabled_reg && scrolling_reg)
                            begin
                                if (dragged_reg)
                                begin
                                    scrolling_reg <= 1'b0;
                                    acc_reg       <= '0;
                                    shape_reg     <= SHAPE_NORMAL;
                                end
                                pend_swallow_reg <= 1'b1;
                            end
                        end
                        KIND_WHEEL:
                        begin
                            pend_swallow_reg <= enabled_reg && scrolling_reg;
                        end
                        KIND_LR_PRESS:
                        begin
                            if (enabled_reg && scrolling_reg)
                            begin
                                scrolling_reg <= 1'b0;
                                acc_reg       <= '0;
                                shape_reg     <= SHAPE_NORMAL;
                            end
                        end
                        KIND_ESCAPE:
                        begin
                            if (scrolling_reg)
                            begin
                                scrolling_reg    <= 1'b0;
                                acc_reg          <= '0;
                                shape_reg        <= SHAPE_NORMAL;
                                pend_swallow_reg <= 1'b1;
                            end
                        end
                        KIND_TOGGLE:
                        begin
                            if (over_reg)
                            begin
                                enabled_reg <= !enabled_reg;
                                if (enabled_reg && scrolling_reg)
                                begin
                                    scrolling_reg <= 1'b0;
                                    acc_reg       <= '0;
                                    shape_reg     <= SHAPE_NORMAL;
                                end
                                pend_swallow_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_swallow_reg <= 1'b0;
                        end
                    endcase
                end
                S_TICK:
                begin
                    if (tick_done)
                    begin
                        if (tick_rsp.dead_hit)
                        begin
                            shape_reg <= SHAPE_MIDDLE;
                            acc_reg   <= '0;
                        end
                        else
                        begin
                            dragged_reg    <= 1'b1;
                            shape_reg      <= tick_rsp.go_down ? SHAPE_SOUTH : SHAPE_NORTH;
                            acc_reg        <= tick_rsp.acc;
                            pend_wv_reg    <= tick_rsp.step_valid;
                            pend_delta_reg <= tick_rsp.step_valid ? tick_rsp.delta : 16'sd0;
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_wv_reg      <= pend_wv_reg;
                        out_delta_reg   <= pend_delta_reg;
                        out_x_reg       <= pend_wv_reg ? anchor_x_reg : 16'sd0;
                        out_y_reg       <= pend_wv_reg ? anchor_y_reg : 16'sd0;
                        out_shape_reg   <= shape_reg;
                        out_scroll_reg  <= scrolling_reg;
                        out_enabled_reg <= enabled_reg;
                        out_swallow_reg <= pend_swallow_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready           = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.wheel_valid   = out_wv_reg;
    assign result.wheel_delta   = out_delta_reg;
    assign result.wheel_x       = out_x_reg;
    assign result.wheel_y       = out_y_reg;
    assign result.cursor_shape  = out_shape_reg;
    assign result.scrolling_now = out_scroll_reg;
    assign result.enabled_now   = out_enabled_reg;
    assign result.swallow       = out_swallow_reg;

endmodule

/* hdl/mcae_cfg_regs.sv */
// Configuration register file of the autoscroll engine.
`timescale 1ns / 1ps

module mcae_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    mcae_cfg_if.sink       cfg,
    output mcae_pkg::cfg_t regs
);
    import mcae_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_DEAD_ZONE:      cfg_reg.dead_zone      <= cfg.data[9:0];
                REG_LINEAR_GAIN:    cfg_reg.linear_gain    <= cfg.data;
                REG_QUADRATIC_GAIN: cfg_reg.quadratic_gain <= cfg.data;
                REG_SPEED_CAP:      cfg_reg.speed_cap      <= cfg.data;
                REG_MAX_STEP:       cfg_reg.max_step       <= cfg.data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* hdl/mcae_mul.sv */
// Shared unsigned 32 by 16 bit multiplier of the speed and step arithmetic.
`timescale 1ns / 1ps

module mcae_mul (
    input  logic [mcae_pkg::MUL_A_W-1:0] a,
    input  logic [mcae_pkg::MUL_B_W-1:0] b,
    output logic [mcae_pkg::MUL_P_W-1:0] p
);
    import mcae_pkg::*;

    assign p = {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};

endmodule

/* hdl/mcae_tick.sv */
// Tick sequencer: speed, step and accumulator update through the shared multiplier.
`timescale 1ns / 1ps

module mcae_tick (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mcae_pkg::tick_req_t req,
    input  mcae_pkg::cfg_t      cfg,
    output logic                done,
    output mcae_pkg::tick_rsp_t rsp
);
    import mcae_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE, T_DIST, T_LIN, T_SQ, T_QUAD, T_CAP, T_STEP, T_ACC, T_WHEEL, T_SUB
    } tstate_t;

    tstate_t                 state_reg;
    tick_req_t               req_reg;
    logic [15:0]             e_reg;
    logic                    neg_reg;
    logic [15:0]             dt_reg;
    logic [31:0]             lin_reg;
    logic [31:0]             sq_reg;
    logic [48:0]             speed_reg;
    logic [31:0]             spd_reg;
    logic [INC_W-1:0]        inc_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      w_reg;
    logic                    wv_reg;
    logic                    done_reg;
    tick_rsp_t               rsp_reg;

    logic signed [16:0]      dy;
    logic [16:0]             abs_dy;
    logic                    dead_hit;
    logic [15:0]             e_val;
    logic [15:0]             dt_val;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [MUL_P_W-1:0]      prod;
    logic [48:0]             speed_sum;
    logic [31:0]             cap;
    logic [31:0]             spd_val;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic [ACC_W-1:0]        mag;
    logic [ACC_INT_BITS-1:0] wmag;
    logic signed [15:0]      w_val;
    logic signed [ACC_W-1:0] acc_left;

    mcae_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (prod)
    );

    always_comb
    begin
        dy       = {req_reg.anchor_y[15], req_reg.anchor_y} - {req_reg.pos_y[15], req_reg.pos_y};
        abs_dy   = dy[16] ? 17'(-dy) : 17'(dy);
        dead_hit = abs_dy <= {7'b0, cfg.dead_zone};
        e_val    = 16'(abs_dy - {7'b0, cfg.dead_zone});
        dt_val   = (req_reg.elapsed < cfg.max_step) ? req_reg.elapsed : cfg.max_step;

        case (state_reg)
            T_LIN:
            begin
                mul_a = {16'b0, e_reg};
                mul_b = cfg.linear_gain;
            end
            T_SQ:
            begin
                mul_a = {16'b0, e_reg};
                mul_b = e_reg;
            end
            T_QUAD:
            begin
                mul_a = sq_reg;
                mul_b = cfg.quadratic_gain;
            end
            T_STEP:
            begin
                mul_a = spd_reg;
                mul_b = dt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        speed_sum = {9'b0, lin_reg, 8'b0} + {1'b0, prod};
        cap       = {cfg.speed_cap, 16'b0};
        spd_val   = (speed_reg > {17'b0, cap}) ? cap : speed_reg[31:0];

        if (neg_reg)
        begin
            acc_sum = {acc_reg[ACC_W-1], acc_reg} - $signed({{(ACC_W+1-INC_W){1'b0}}, inc_reg});
        end
        else
        begin
            acc_sum = {acc_reg[ACC_W-1], acc_reg} + $signed({{(ACC_W+1-INC_W){1'b0}}, inc_reg});
        end
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end

        mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        wmag = mag[ACC_W-1:FRAC_BITS];
        if (wmag[ACC_INT_BITS-1:15] != '0)
        begin
            w_val = acc_reg[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            w_val = acc_reg[ACC_W-1] ? 16'(-wmag[15:0]) : 16'(wmag[15:0]);
        end

        acc_left = acc_reg - {{(ACC_INT_BITS-16){w_reg[15]}}, w_reg, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            req_reg   <= '0;
            e_reg     <= '0;
            neg_reg   <= 1'b0;
            dt_reg    <= '0;
            lin_reg   <= '0;
            sq_reg    <= '0;
            speed_reg <= '0;
            spd_reg   <= '0;
            inc_reg   <= '0;
            acc_reg   <= '0;
            w_reg     <= '0;
            wv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        acc_reg   <= req.acc;
                        state_reg <= T_DIST;
                    end
                end
                T_DIST:
                begin
                    e_reg   <= e_val;
                    neg_reg <= dy[16];
                    dt_reg  <= dt_val;
                    if (dead_hit)
                    begin
                        rsp_reg   <= '{dead_hit: 1'b1, go_down: 1'b0, step_valid: 1'b0,
                                       delta: '0, acc: '0};
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                    else
                    begin
                        state_reg <= T_LIN;
                    end
                end
                T_LIN:
                begin
                    lin_reg   <= prod[31:0];
                    state_reg <= T_SQ;
                end
                T_SQ:
                begin
                    sq_reg    <= prod[31:0];
                    state_reg <= T_QUAD;
                end
                T_QUAD:
                begin
                    speed_reg <= speed_sum;
                    state_reg <= T_CAP;
                end
                T_CAP:
                begin
                    spd_reg   <= spd_val;
                    state_reg <= T_STEP;
                end
                T_STEP:
                begin
                    inc_reg   <= prod[MUL_P_W-1:STEP_SHIFT];
                    state_reg <= T_ACC;
                end
                T_ACC:
                begin
                    acc_reg   <= acc_sat;
                    state_reg <= T_WHEEL;
                end
                T_WHEEL:
                begin
                    w_reg     <= w_val;
                    wv_reg    <= wmag != '0;
                    state_reg <= T_SUB;
                end
                T_SUB:
                begin
                    rsp_reg   <= '{dead_hit: 1'b0, go_down: neg_reg, step_valid: wv_reg,
                                   delta: w_reg, acc: acc_left};
                    done_reg  <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* hdl/mcae_checker.sv */
// Port-level checker of the autoscroll engine and its binding to the top level.
`timescale 1ns / 1ps

module mcae_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               wheel_valid,
    input logic signed [15:0] wheel_delta,
    input logic signed [15:0] wheel_x,
    input logic signed [15:0] wheel_y,
    input logic [1:0]         cursor_shape,
    input logic               scrolling_now,
    input logic               enabled_now
);
    import mcae_pkg::*;

    // A stalled result word keeps its step fields, cursor shape and scrolling flag unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheel_delta) && $stable(wheel_x)
            && $stable(wheel_y) && $stable(cursor_shape) && $stable(scrolling_now))
        else $error("result word changed while stalled");

    // A wheel step always moves by a nonzero amount.
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wheel_valid |-> wheel_delta != 16'sd0)
        else $error("wheel step with zero amount");

    // Without a wheel step the step fields read zero.
    a_no_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wheel_valid |-> wheel_delta == 16'sd0 && wheel_x == 16'sd0
            && wheel_y == 16'sd0)
        else $error("step fields not cleared without a wheel step");

    // When not scrolling, the normal cursor is shown and no step goes out.
    a_idle_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !scrolling_now |-> cursor_shape == SHAPE_NORMAL && !wheel_valid)
        else $error("cursor or step while not scrolling");

    // Scrolling never continues while the feature is disabled.
    a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !enabled_now |-> !scrolling_now)
        else $error("scrolling while disabled");

endmodule

bind middle_click_autoscroll_engine_unit mcae_checker u_mcae_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .wheel_valid   (result.wheel_valid),
    .wheel_delta   (result.wheel_delta),
    .wheel_x       (result.wheel_x),
    .wheel_y       (result.wheel_y),
    .cursor_shape  (result.cursor_shape),
    .scrolling_now (result.scrolling_now),
    .enabled_now   (result.enabled_now)
);
